// ===== rtl/sce_pkg.sv =====
// Package for the flame scan, confirm and extinguish controller.
// Holds the mode codes, register indexes, reset values and the structs shared
// by the register file, the state core and the result emitter.
package sce_pkg;

   // Widths of the stored values.
   localparam int STEP_W   = 6;
   localparam int HALF_W   = 4;
   localparam int PULSE_W  = 12;
   localparam int SAMPLE_W = 10;
   localparam int COUNT_W  = 4;
   localparam int RUN_W    = 6;   // beat counter, holds up to four times the half-width

   // Default number of sweep steps.
   localparam int SWEEP_STEPS_DEFAULT = 60;

   // Counter and half-width limits.
   localparam logic signed [COUNT_W-1:0] RELEASE_BOUND  = -4'sd2;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX      = 4'sd7;
   localparam logic [HALF_W-1:0]         HALF_WIDTH_MAX = 4'd8;

   // Operating modes as reported on the result channel.
   typedef enum logic [1:0] {
      MODE_SWEEP   = 2'd0,
      MODE_CONFIRM = 2'd1,
      MODE_PUMP    = 2'd2
   } mode_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_TRIP_LEVEL       = 3'd0,
      REG_CONFIRM_LIMIT    = 3'd1,
      REG_LEFT_END_PULSE   = 3'd2,
      REG_RIGHT_END_PULSE  = 3'd3,
      REG_PULSE_PER_STEP   = 3'd4,
      REG_WATER_HALF_WIDTH = 3'd5
   } reg_index_type;

   // Register reset values.
   localparam logic [9:0]  RST_TRIP_LEVEL       = 10'd100;
   localparam logic [3:0]  RST_CONFIRM_LIMIT    = 4'd3;
   localparam logic [11:0] RST_LEFT_END_PULSE   = 12'd900;
   localparam logic [11:0] RST_RIGHT_END_PULSE  = 12'd2100;
   localparam logic [7:0]  RST_PULSE_PER_STEP   = 8'd20;
   localparam logic [3:0]  RST_WATER_HALF_WIDTH = 4'd4;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [9:0]  trip_level;
      logic [3:0]  confirm_limit;
      logic [11:0] left_end_pulse;
      logic [11:0] right_end_pulse;
      logic [7:0]  pulse_per_step;
      logic [3:0]  water_half_width;
   } cfg_type;

   // What one accepted sample asks the emitter to produce.
   typedef struct packed {
      logic              run;     // watering run instead of a single beat
      logic [STEP_W-1:0] step;
      logic              dir;
      logic              alarm;
      mode_type          mode;
   } job_type;

endpackage

// ===== rtl/sce_csr.sv =====
// Configuration register file of the flame controller, APB-style access.
// Depends on sce_pkg for the register indexes, reset values and cfg_type.
module sce_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output sce_pkg::cfg_type cfg
);

   sce_pkg::cfg_type      cfg_ff;
   sce_pkg::cfg_type      cfg_in;
   sce_pkg::reg_index_type idx;
   logic                  wr_en;

   assign idx   = sce_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg   = cfg_ff;

   // Write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            sce_pkg::REG_TRIP_LEVEL:       cfg_in.trip_level       = csr_pwdata[9:0];
            sce_pkg::REG_CONFIRM_LIMIT:    cfg_in.confirm_limit    = csr_pwdata[3:0];
            sce_pkg::REG_LEFT_END_PULSE:   cfg_in.left_end_pulse   = csr_pwdata[11:0];
            sce_pkg::REG_RIGHT_END_PULSE:  cfg_in.right_end_pulse  = csr_pwdata[11:0];
            sce_pkg::REG_PULSE_PER_STEP:   cfg_in.pulse_per_step   = csr_pwdata[7:0];
            sce_pkg::REG_WATER_HALF_WIDTH: cfg_in.water_half_width = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_level       <= sce_pkg::RST_TRIP_LEVEL;
         cfg_ff.confirm_limit    <= sce_pkg::RST_CONFIRM_LIMIT;
         cfg_ff.left_end_pulse   <= sce_pkg::RST_LEFT_END_PULSE;
         cfg_ff.right_end_pulse  <= sce_pkg::RST_RIGHT_END_PULSE;
         cfg_ff.pulse_per_step   <= sce_pkg::RST_PULSE_PER_STEP;
         cfg_ff.water_half_width <= sce_pkg::RST_WATER_HALF_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (idx)
         sce_pkg::REG_TRIP_LEVEL:       csr_prdata = {22'd0, cfg_ff.trip_level};
         sce_pkg::REG_CONFIRM_LIMIT:    csr_prdata = {28'd0, cfg_ff.confirm_limit};
         sce_pkg::REG_LEFT_END_PULSE:   csr_prdata = {20'd0, cfg_ff.left_end_pulse};
         sce_pkg::REG_RIGHT_END_PULSE:  csr_prdata = {20'd0, cfg_ff.right_end_pulse};
         sce_pkg::REG_PULSE_PER_STEP:   csr_prdata = {24'd0, cfg_ff.pulse_per_step};
         sce_pkg::REG_WATER_HALF_WIDTH: csr_prdata = {28'd0, cfg_ff.water_half_width};
         default:                       csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== rtl/sce_core.sv =====
// Mode state machine of the flame controller: sweep, confirm and pump.
// Updates the stored state on each accepted sample and describes the job.
// Depends on sce_pkg for mode_type, cfg_type and job_type.
module sce_core #(
   parameter int SWEEP_STEPS = sce_pkg::SWEEP_STEPS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [sce_pkg::SAMPLE_W-1:0] sample,
   input  sce_pkg::cfg_type          cfg,
   output sce_pkg::job_type          job
);

   sce_pkg::mode_type                  mode_ff, mode_in;
   logic                               dir_ff, dir_in;
   logic [sce_pkg::STEP_W-1:0]         step_ff, step_in, step_inc;
   logic signed [sce_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                               alarm_ff, alarm_in;
   logic                               above, below, confirmed, run;

   assign above    = sample > cfg.trip_level;
   assign below    = sample < cfg.trip_level;
   assign step_inc = step_ff + 1'b1;

   // Next state and job for the sample on the input.
   always_comb begin
      mode_in   = mode_ff;
      dir_in    = dir_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      alarm_in  = alarm_ff;
      run       = 1'b0;
      confirmed = 1'b0;
      case (mode_ff)
         sce_pkg::MODE_CONFIRM: begin
            if (above) begin
               if (count_ff >= sce_pkg::RELEASE_BOUND) begin
                  count_in = count_ff - 4'sd1;
               end else begin
                  count_in = '0;
                  mode_in  = sce_pkg::MODE_SWEEP;
               end
            end else if (count_ff < sce_pkg::COUNT_MAX) begin
               count_in = count_ff + 4'sd1;
            end
            // A nonnegative counter confirms once it passes the limit.
            confirmed = !count_in[sce_pkg::COUNT_W-1] &&
                        ({1'b0, count_in[sce_pkg::COUNT_W-2:0]} > cfg.confirm_limit);
            if (confirmed) begin
               alarm_in = 1'b1;
               mode_in  = sce_pkg::MODE_PUMP;
               run      = 1'b1;
            end
         end
         sce_pkg::MODE_PUMP: begin
            if (above) begin
               alarm_in = 1'b0;
               count_in = '0;
               mode_in  = sce_pkg::MODE_SWEEP;
            end else begin
               run = 1'b1;
            end
         end
         default: begin
            // Sweep, and the unused code behaves the same.
            mode_in = sce_pkg::MODE_SWEEP;
            if (below) begin
               mode_in = sce_pkg::MODE_CONFIRM;
            end else if (step_inc >= sce_pkg::STEP_W'(SWEEP_STEPS)) begin
               step_in = '0;
               dir_in  = !dir_ff;
            end else begin
               step_in = step_inc;
            end
         end
      endcase
      job.run   = run;
      job.step  = step_in;
      job.dir   = dir_in;
      job.alarm = alarm_in;
      job.mode  = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sce_pkg::MODE_SWEEP;
         dir_ff   <= 1'b0;
         step_ff  <= '0;
         count_ff <= '0;
         alarm_ff <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         dir_ff   <= dir_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         alarm_ff <= alarm_in;
      end
   end

endmodule

// ===== rtl/sce_emit.sv =====
// Result emitter of the flame controller: output register, watering-run beat
// counter and servo pulse arithmetic. Depends on sce_pkg.
module sce_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   output logic                        take,
   input  sce_pkg::job_type            job,
   input  sce_pkg::cfg_type            cfg,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   // Run context, held while a watering run has beats left.
   logic                            run_ff, run_in;
   logic [sce_pkg::RUN_W-1:0]       k_ff, k_in;
   logic [sce_pkg::HALF_W-1:0]      h_ff, h_in;
   logic [sce_pkg::STEP_W-1:0]      s_ff;
   logic                            dir_ff, alarm_ff;
   sce_pkg::mode_type               mode_ff;

   // Output register.
   logic                            valid_ff, valid_in;
   logic [sce_pkg::PULSE_W-1:0]     pulse_ff;
   logic                            pump_ff, alarm_out_ff, last_ff;
   sce_pkg::mode_type               mode_out_ff;

   // Current beat.
   logic                            out_free, load;
   logic [sce_pkg::RUN_W-1:0]       k;
   logic [sce_pkg::HALF_W-1:0]      h, h_clamp;
   logic [sce_pkg::STEP_W-1:0]      s;
   logic                            dir, alarm, pump, last;
   sce_pkg::mode_type               mode;
   logic [7:0]                      k8, h8, off;
   logic signed [7:0]               idx;
   logic [sce_pkg::PULSE_W-1:0]     prod, pulse;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = out_free && !run_ff;
   assign take       = req_tvalid && req_tready;
   assign load       = out_free && (run_ff || req_tvalid);
   assign h_clamp    = (cfg.water_half_width > sce_pkg::HALF_WIDTH_MAX) ?
                       sce_pkg::HALF_WIDTH_MAX : cfg.water_half_width;

   // Beat source: an ongoing run, or the first beat of a new job.
   // A single result is a run with zero half-width.
   always_comb begin
      if (run_ff) begin
         k = k_ff; h = h_ff; s = s_ff; dir = dir_ff;
         alarm = alarm_ff; mode = mode_ff; pump = 1'b1;
      end else begin
         k = '0; h = job.run ? h_clamp : '0; s = job.step; dir = job.dir;
         alarm = job.alarm; mode = job.mode; pump = job.run;
      end
   end

   // Step offset: rising from s-h up to s+h-1, then falling from s+h to s-h.
   always_comb begin
      k8 = {2'b00, k};
      h8 = {4'b0000, h};
      if (k8 < (h8 << 1)) begin
         off = k8 - h8;
      end else begin
         off = h8 + (h8 << 1) - k8;
      end
      idx  = $signed({2'b00, s} + off);
      last = (k8 == (h8 << 2));
      prod = sce_pkg::PULSE_W'({{4{idx[7]}}, idx} * {4'b0000, cfg.pulse_per_step});
      pulse = dir ? (cfg.left_end_pulse + prod) : (cfg.right_end_pulse - prod);
   end

   // Run context update.
   always_comb begin
      run_in = run_ff;
      k_in   = k_ff;
      h_in   = h_ff;
      if (load) begin
         run_in = !last;
         k_in   = k + 1'b1;
         h_in   = h;
      end
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         valid_ff <= 1'b0;
         k_ff     <= '0;
         h_ff     <= '0;
      end else begin
         run_ff   <= run_in;
         valid_ff <= valid_in;
         k_ff     <= k_in;
         h_ff     <= h_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         s_ff     <= job.step;
         dir_ff   <= job.dir;
         alarm_ff <= job.alarm;
         mode_ff  <= job.mode;
      end
      if (load) begin
         pulse_ff     <= pulse;
         pump_ff      <= pump;
         alarm_out_ff <= alarm;
         mode_out_ff  <= mode;
         last_ff      <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, alarm_out_ff, pump_ff, pulse_ff};
   assign rsp_tuser  = mode_out_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/scan_confirm_extinguish_controller.sv =====
// Flame scan, confirm and extinguish controller, top level.
// A result is in the output register in the cycle after its sample beat is taken.
// Throughput: one sample per cycle while each yields a single result and the result
// channel is ready; a sample that starts a watering run of 4*h+1 beats (h the clamped
// half-width) holds off input until the emitter's beat counter loads the last beat.
// Synchronous reset clears mode state and output valid, and restores register defaults.
module scan_confirm_extinguish_controller #(
   parameter int SWEEP_STEPS = sce_pkg::SWEEP_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Sample beats.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] sample
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [11:0] servo_pulse, [12] pump_on, [13] alarm
   output logic [1:0]  rsp_tuser,    // [1:0] mode
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   sce_pkg::cfg_type cfg;
   sce_pkg::job_type job;
   logic             take;

   assign csr_pready = 1'b1;

   // Register file.
   sce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // Mode state machine.
   sce_core #(
      .SWEEP_STEPS (SWEEP_STEPS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_tdata[sce_pkg::SAMPLE_W-1:0]),
      .cfg    (cfg),
      .job    (job)
   );

   // Result emitter.
   sce_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .take       (take),
      .job        (job),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
